// ===== rtl/plist_pkg.sv =====
// ----------------------------------------------------------------------------
// plist_pkg: shared types and codes of the positional list engine
// Request codes, status codes, the decoded request that crosses the queue
// between the front and back parts, and the fixed field widths.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int REQ_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 5;
  localparam int STAT_W = 2;

  // Request type codes on the input port.
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_END   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_POS   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_POS   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd6;
  localparam logic [REQ_W-1:0] REQ_READ_OUT  = 3'd7;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_INS    = 2'd0,
    OP_DEL    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_FRONT = 2'd0,
    SEL_END   = 2'd1,
    SEL_ARG   = 2'd2
  } sel_t;

  typedef struct packed {
    op_t               op;
    sel_t              sel;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } req_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

// ===== rtl/plist_front.sv =====
// ----------------------------------------------------------------------------
// plist_front: request decode and queue
// Accepts input transactions, classifies each one into an operation and a
// position selector, and holds them in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module plist_front import plist_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic [POS_W-1:0]         in_item_position,
  output logic                     q_valid,
  output req_t                     q_req,
  input  logic                     q_pop
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  req_t           q_mem_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  req_t           dec;
  logic           push;

  always_comb begin
    dec.value    = in_item_value;
    dec.position = in_item_position;
    unique case (in_req_type) inside
      REQ_INS_FRONT, REQ_INS_END, REQ_INS_POS: dec.op = OP_INS;
      REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_POS: dec.op = OP_DEL;
      REQ_SEARCH: dec.op = OP_SEARCH;
      default: dec.op = OP_READ;
    endcase
    unique case (in_req_type) inside
      REQ_INS_FRONT, REQ_DEL_FIRST: dec.sel = SEL_FRONT;
      REQ_INS_END, REQ_DEL_LAST: dec.sel = SEL_END;
      default: dec.sel = SEL_ARG;
    endcase
  end

  assign in_stall = (cnt_r == QCW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_req    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        q_mem_r[wr_ptr_r] <= dec;
        wr_ptr_r          <= (wr_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (q_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/plist_back.sv =====
// ----------------------------------------------------------------------------
// plist_back: list sequencer
// Executes one queued request at a time against the element memory: shifts
// entries one per cycle for positional inserts and deletes, scans for a
// search, walks the list for a read-out, and drives the output register.
// ----------------------------------------------------------------------------
module plist_back import plist_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  req_t                     q_req,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_found,
  output logic [CNT_W-1:0]         out_hit_position,
  output logic signed [DATA_W-1:0] out_elem_value,
  output logic                     out_elem_valid,
  output logic [CNT_W-1:0]         out_length_now,
  output logic                     out_last
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = ((LW > POS_W) ? LW : POS_W) + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOVE  = 7'b0000010,
    S_DRAIN = 7'b0000100,
    S_PUT   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t            state_r;
  logic [LW-1:0]     len_r;
  logic [LW-1:0]     idx_r;
  logic [LW-1:0]     end_r;
  logic              dir_up_r;
  logic [DATA_W-1:0] val_r;
  logic              wb_vld_r;
  logic [AW-1:0]     wb_addr_r;
  logic              cmp_vld_r;
  logic [LW-1:0]     cmp_idx_r;
  status_t           rsp_status_r;
  logic              rsp_found_r;
  logic [LW-1:0]     rsp_hit_r;
  logic [DATA_W-1:0] rsp_value_r;
  logic              rsp_valid_r;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  logic              out_valid_r;
  status_t           out_status_r;
  logic              out_found_r;
  logic [CNT_W-1:0]  out_hit_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_elem_valid_r;
  logic [CNT_W-1:0]  out_len_r;
  logic              out_last_r;

  logic              out_ready;
  logic              out_load;
  logic [PW-1:0]     len_ext;
  logic [PW-1:0]     ins_p;
  logic [PW-1:0]     del_p;
  logic              full;
  logic              ins_bad;
  logic              del_bad;
  logic [LW-1:0]     ins_idx;
  logic [LW-1:0]     del_src;
  logic [LW-1:0]     idx_nx;
  logic              emit_last;

  assign out_ready = !out_valid_r || !out_stall;
  assign out_load  = out_ready && ((state_r == S_EMIT) || (state_r == S_RESP));
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign idx_nx    = idx_r + 1'b1;
  assign emit_last = (idx_nx == len_r);

  // Resolve the target position of the head request against the current length.
  always_comb begin
    len_ext = PW'(len_r);
    case (q_req.sel)
      SEL_FRONT: ins_p = PW'(1);
      SEL_END:   ins_p = len_ext + 1'b1;
      default:   ins_p = PW'(q_req.position);
    endcase
    case (q_req.sel)
      SEL_FRONT: del_p = PW'(1);
      SEL_END:   del_p = len_ext;
      default:   del_p = PW'(q_req.position);
    endcase
    full    = (len_r >= LW'(CAPACITY));
    ins_bad = (ins_p == '0) || (ins_p > len_ext + 1'b1);
    del_bad = (del_p == '0) || (del_p > len_ext);
    ins_idx = LW'(ins_p - 1'b1);
    del_src = LW'(del_p);
  end

  // Read address: the read-out prefetches the next element once the current
  // one leaves, so results stream at one per cycle while the output is not stalled.
  always_comb begin
    case (state_r)
      S_MOVE, S_SCAN: rd_addr = idx_r[AW-1:0];
      S_EMIT: rd_addr = (out_ready && !emit_last) ? idx_nx[AW-1:0] : idx_r[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  assign mem_we    = wb_vld_r || (state_r == S_PUT);
  assign mem_waddr = (state_r == S_PUT) ? end_r[AW-1:0] : wb_addr_r;
  assign mem_wdata = (state_r == S_PUT) ? val_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      wb_vld_r    <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            val_r        <= q_req.value;
            rsp_found_r  <= 1'b0;
            rsp_hit_r    <= '0;
            rsp_value_r  <= '0;
            rsp_valid_r  <= 1'b0;
            case (q_req.op)
              OP_INS: begin
                if (full) begin
                  rsp_status_r <= ST_FULL;
                  state_r      <= S_RESP;
                end else if (ins_bad) begin
                  rsp_status_r <= ST_IGNORED;
                  state_r      <= S_RESP;
                end else if (ins_idx == len_r) begin
                  rsp_status_r <= ST_DONE;
                  end_r        <= ins_idx;
                  state_r      <= S_PUT;
                end else begin
                  rsp_status_r <= ST_DONE;
                  idx_r        <= len_r - 1'b1;
                  end_r        <= ins_idx;
                  dir_up_r     <= 1'b1;
                  state_r      <= S_MOVE;
                end
              end
              OP_DEL: begin
                if (del_bad) begin
                  rsp_status_r <= ST_IGNORED;
                  state_r      <= S_RESP;
                end else if (del_src == len_r) begin
                  rsp_status_r <= ST_DONE;
                  len_r        <= len_r - 1'b1;
                  state_r      <= S_RESP;
                end else begin
                  rsp_status_r <= ST_DONE;
                  idx_r        <= del_src;
                  end_r        <= len_r - 1'b1;
                  dir_up_r     <= 1'b0;
                  state_r      <= S_MOVE;
                end
              end
              OP_SEARCH: begin
                rsp_status_r <= ST_DONE;
                idx_r        <= '0;
                cmp_vld_r    <= 1'b0;
                state_r      <= S_SCAN;
              end
              default: begin
                if (len_r == '0) begin
                  rsp_status_r <= ST_IGNORED;
                  state_r      <= S_RESP;
                end else begin
                  idx_r   <= '0;
                  state_r <= S_EMIT;
                end
              end
            endcase
          end
        end
        S_MOVE: begin
          // Each entry read here is written one slot over in the next cycle.
          wb_vld_r  <= 1'b1;
          wb_addr_r <= dir_up_r ? AW'(idx_r + 1'b1) : AW'(idx_r - 1'b1);
          if (idx_r == end_r) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= dir_up_r ? idx_r - 1'b1 : idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          wb_vld_r <= 1'b0;
          if (dir_up_r) begin
            state_r <= S_PUT;
          end else begin
            len_r   <= len_r - 1'b1;
            state_r <= S_RESP;
          end
        end
        S_PUT: begin
          len_r   <= len_r + 1'b1;
          state_r <= S_RESP;
        end
        S_SCAN: begin
          // rd_data_r holds the entry at cmp_idx_r, read in the previous cycle.
          if (cmp_vld_r && (rd_data_r == val_r)) begin
            rsp_found_r <= 1'b1;
            rsp_hit_r   <= cmp_idx_r + 1'b1;
            rsp_value_r <= rd_data_r;
            rsp_valid_r <= 1'b1;
            cmp_vld_r   <= 1'b0;
            state_r     <= S_RESP;
          end else if (idx_r == len_r) begin
            cmp_vld_r <= 1'b0;
            state_r   <= S_RESP;
          end else begin
            cmp_vld_r <= 1'b1;
            cmp_idx_r <= idx_r;
            idx_r     <= idx_nx;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_status_r     <= ST_DONE;
            out_found_r      <= 1'b0;
            out_hit_r        <= '0;
            out_value_r      <= rd_data_r;
            out_elem_valid_r <= 1'b1;
            out_len_r        <= CNT_W'(len_r);
            out_last_r       <= emit_last;
            if (emit_last) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_nx;
            end
          end
        end
        S_RESP: begin
          if (out_ready) begin
            out_status_r     <= rsp_status_r;
            out_found_r      <= rsp_found_r;
            out_hit_r        <= CNT_W'(rsp_hit_r);
            out_value_r      <= rsp_value_r;
            out_elem_valid_r <= rsp_valid_r;
            out_len_r        <= CNT_W'(len_r);
            out_last_r       <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found        = out_found_r;
  assign out_hit_position = out_hit_r;
  assign out_elem_value   = out_value_r;
  assign out_elem_valid   = out_elem_valid_r;
  assign out_length_now   = out_len_r;
  assign out_last         = out_last_r;

endmodule

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list of signed 32-bit values
// Top level joining the request front end and the list sequencer.
// ----------------------------------------------------------------------------
// The list lives packed in a memory of CAPACITY words with one read and one
// write port. Requests enter a two-entry queue and are executed one at a time.
// Inserting at 1-based position p moves each entry from p on up one slot,
// drains the last write, writes the new value and issues the result;
// appending writes the value at once. Deleting position p moves each later
// entry down one slot, drains and issues the result; deleting the last
// element only shortens the list. A search scans from the first element and
// stops early on a hit. A read-out delivers one transaction per element per
// cycle while the output is not stalled. Refused or ignored requests only
// issue the result. Results pass through an output register; a stalled
// result holds the sequencer; the queue still takes up to two more requests.
// ----------------------------------------------------------------------------
module positional_list_engine import plist_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic [POS_W-1:0]         in_item_position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        out_status,
  output logic                     out_found,
  output logic [CNT_W-1:0]         out_hit_position,
  output logic signed [DATA_W-1:0] out_elem_value,
  output logic                     out_elem_valid,
  output logic [CNT_W-1:0]         out_length_now,
  output logic                     out_last
);

  logic q_valid;
  req_t q_req;
  logic q_pop;

  plist_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_item_value    (in_item_value),
    .in_item_position (in_item_position),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_pop            (q_pop)
  );

  plist_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_hit_position (out_hit_position),
    .out_elem_value   (out_elem_value),
    .out_elem_valid   (out_elem_valid),
    .out_length_now   (out_length_now),
    .out_last         (out_last)
  );

endmodule
